FILE: rtl/poisson_residual_rms_norm_unit_macros.svh
// assertion macros for the poisson residual rms norm unit
// used by the top level only, no other dependencies
`ifndef POISSON_RESIDUAL_RMS_NORM_UNIT_MACROS_SVH
`define POISSON_RESIDUAL_RMS_NORM_UNIT_MACROS_SVH

// same-cycle implication under reset
`define PRRN_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define PRRN_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/prrn_pkg.sv
// shared constants and types of the poisson residual rms norm unit
// no dependencies
`default_nettype none

package prrn_pkg;

    localparam int COUNT_BITS_DEF = 24;
    localparam int VALUE_BITS_DEF = 32;
    localparam int FRAC_BITS      = 16;
    localparam int OUT_COUNT_BITS = 24;
    localparam int SUM_BITS       = 64;
    localparam int DIV_STEPS      = 64;
    localparam int ROOT_STEPS     = 32;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [31:0] INV_SQ_RESET = 32'h0001_0000;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_INV_DX_SQ = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INV_DY_SQ = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_ROOT = 4'b0100,
        ST_OUT  = 4'b1000
    } back_state_t;

endpackage

`default_nettype wire

FILE: rtl/prrn_front.sv
// front pipeline: stencil residual, square and saturating accumulation
// depends on prrn_pkg
`default_nettype none

module prrn_front #(
    parameter int COUNT_BITS = prrn_pkg::COUNT_BITS_DEF,
    parameter int VALUE_BITS = prrn_pkg::VALUE_BITS_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic signed [31:0]      cell_value,
    input  wire logic signed [31:0]      east_face,
    input  wire logic signed [31:0]      west_face,
    input  wire logic signed [31:0]      north_face,
    input  wire logic signed [31:0]      south_face,
    input  wire logic signed [31:0]      source_term,
    input  wire logic                    first_cell,
    input  wire logic                    last_cell,
    input  wire logic [31:0]             inv_dx_sq,
    input  wire logic [31:0]             inv_dy_sq,
    input  wire logic                    q_full,
    output logic                         q_push,
    output logic [63:0]                  snap_sum,
    output logic [COUNT_BITS-1:0]        snap_count,
    output logic                         snap_flag
);

    localparam logic signed [55:0] VMAX =
        56'((64'd1 << (VALUE_BITS - 1)) - 64'd1);
    localparam logic signed [55:0] VMIN = -VMAX - 56'sd1;

    logic enable;

    // stage 1
    logic v1_reg, first1_reg, last1_reg;
    logic signed [31:0] c1_reg, e1_reg, w1_reg, n1_reg, s1_reg, src1_reg;
    // stage 2
    logic v2_reg, first2_reg, last2_reg, negx2_reg, negy2_reg;
    logic [50:0] pxh2_reg, pxl2_reg, pyh2_reg, pyl2_reg;
    logic signed [31:0] src2_reg;
    // stage 3
    logic v3_reg, first3_reg, last3_reg;
    logic signed [55:0] tx3_reg, ty3_reg;
    logic signed [31:0] src3_reg;
    // stage 4
    logic v4_reg, first4_reg, last4_reg, clamp4_reg;
    logic [47:0] m4_reg;
    // stage 5
    logic v5_reg, first5_reg, last5_reg, clamp5_reg, big5_reg;
    logic [47:0] aa5_reg;
    logic [39:0] ab5_reg;
    logic [31:0] bb5_reg;
    // stage 6
    logic v6_reg, first6_reg, last6_reg, clamp6_reg, sqsat6_reg;
    logic [63:0] sq6_reg;

    // accumulator
    logic [63:0]           sum_reg, sum_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  flag_reg, flag_next;

    logic signed [35:0] lx, ly;
    logic [34:0] mx, my;
    logic [50:0] pxh, pxl, pyh, pyl;
    logic [50:0] tx_mag, ty_mag;
    logic signed [55:0] tx, ty, r, rc;
    logic clampf;
    logic [47:0] m;
    logic [31:0] a;
    logic [47:0] aa;
    logic [39:0] ab;
    logic [31:0] bb;
    logic [41:0] add;
    logic [64:0] hisum;
    logic [63:0] base_sum;
    logic [COUNT_BITS-1:0] base_count;
    logic base_flag;
    logic [64:0] sum_add;
    logic sum_ovf, count_full;

    assign enable   = !(v6_reg && last6_reg && q_full);
    assign in_stall = !enable;

    // reflected neighbours give 2*(a+b) - 4*centre
    always_comb
    begin
        lx = ((36'(e1_reg) + 36'(w1_reg)) <<< 1) - (36'(c1_reg) <<< 2);
        ly = ((36'(n1_reg) + 36'(s1_reg)) <<< 1) - (36'(c1_reg) <<< 2);
        mx = lx[35] ? 35'(-lx) : 35'(lx);
        my = ly[35] ? 35'(-ly) : 35'(ly);
        pxh = 51'(mx) * 51'(inv_dx_sq[31:16]);
        pxl = 51'(mx) * 51'(inv_dx_sq[15:0]);
        pyh = 51'(my) * 51'(inv_dy_sq[31:16]);
        pyl = 51'(my) * 51'(inv_dy_sq[15:0]);
    end

    always_comb
    begin
        tx_mag = pxh2_reg + (pxl2_reg >> prrn_pkg::FRAC_BITS);
        ty_mag = pyh2_reg + (pyl2_reg >> prrn_pkg::FRAC_BITS);
        tx = negx2_reg ? -56'(tx_mag) : 56'(tx_mag);
        ty = negy2_reg ? -56'(ty_mag) : 56'(ty_mag);
    end

    always_comb
    begin
        r = tx3_reg + ty3_reg - 56'(src3_reg);
        clampf = 1'b0;
        rc = r;
        if (r > VMAX)
        begin
            rc = VMAX;
            clampf = 1'b1;
        end
        else if (r < VMIN)
        begin
            rc = VMIN;
            clampf = 1'b1;
        end
        m = rc[55] ? 48'(-rc) : 48'(rc);
    end

    always_comb
    begin
        a  = m4_reg[47:16];
        aa = 48'(a[23:0]) * 48'(a[23:0]);
        ab = 40'(a[23:0]) * 40'(m4_reg[15:0]);
        bb = 32'(m4_reg[15:0]) * 32'(m4_reg[15:0]);
    end

    always_comb
    begin
        add   = 42'({ab5_reg, 1'b0}) + 42'(bb5_reg[31:16]);
        hisum = 65'({aa5_reg, 16'h0000}) + 65'(add);
    end

    always_comb
    begin
        base_sum   = first6_reg ? 64'd0 : sum_reg;
        base_count = first6_reg ? '0 : count_reg;
        base_flag  = first6_reg ? 1'b0 : flag_reg;
        sum_add    = {1'b0, base_sum} + {1'b0, sq6_reg};
        sum_ovf    = sqsat6_reg || sum_add[64];
        sum_next   = sum_ovf ? '1 : sum_add[63:0];
        count_full = (base_count == '1);
        count_next = count_full ? base_count : base_count + 1'b1;
        flag_next  = base_flag || clamp6_reg || sum_ovf || count_full;
    end

    assign q_push     = v6_reg && last6_reg && enable;
    assign snap_sum   = sum_next;
    assign snap_count = count_next;
    assign snap_flag  = flag_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            v5_reg    <= 1'b0;
            v6_reg    <= 1'b0;
            sum_reg   <= '0;
            count_reg <= '0;
            flag_reg  <= 1'b0;
        end
        else if (enable)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            if (v6_reg)
            begin
                sum_reg   <= sum_next;
                count_reg <= count_next;
                flag_reg  <= flag_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            c1_reg     <= cell_value;
            e1_reg     <= east_face;
            w1_reg     <= west_face;
            n1_reg     <= north_face;
            s1_reg     <= south_face;
            src1_reg   <= source_term;
            first1_reg <= first_cell;
            last1_reg  <= last_cell;

            pxh2_reg   <= pxh;
            pxl2_reg   <= pxl;
            pyh2_reg   <= pyh;
            pyl2_reg   <= pyl;
            negx2_reg  <= lx[35];
            negy2_reg  <= ly[35];
            src2_reg   <= src1_reg;
            first2_reg <= first1_reg;
            last2_reg  <= last1_reg;

            tx3_reg    <= tx;
            ty3_reg    <= ty;
            src3_reg   <= src2_reg;
            first3_reg <= first2_reg;
            last3_reg  <= last2_reg;

            m4_reg     <= m;
            clamp4_reg <= clampf;
            first4_reg <= first3_reg;
            last4_reg  <= last3_reg;

            aa5_reg    <= aa;
            ab5_reg    <= ab;
            bb5_reg    <= bb;
            big5_reg   <= |a[31:24];
            clamp5_reg <= clamp4_reg;
            first5_reg <= first4_reg;
            last5_reg  <= last4_reg;

            sq6_reg    <= hisum[63:0];
            sqsat6_reg <= big5_reg || hisum[64];
            clamp6_reg <= clamp5_reg;
            first6_reg <= first5_reg;
            last6_reg  <= last5_reg;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/prrn_queue.sv
// two-word queue of accumulator snapshots between front and back
// depends on nothing but its width parameter
`default_nettype none

module prrn_queue #(
    parameter int WIDTH = 89
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      head_data,
    output logic                  not_empty,
    output logic                  full
);

    logic             head_valid_reg, tail_valid_reg;
    logic [WIDTH-1:0] head_reg, tail_reg;

    assign head_data = head_reg;
    assign not_empty = head_valid_reg;
    assign full      = tail_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            tail_valid_reg <= 1'b0;
        end
        else if (pop && !push)
        begin
            head_valid_reg <= tail_valid_reg;
            tail_valid_reg <= 1'b0;
        end
        else if (push && !pop)
        begin
            if (head_valid_reg)
                tail_valid_reg <= 1'b1;
            else
                head_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && push)
        begin
            if (tail_valid_reg)
            begin
                head_reg <= tail_reg;
                tail_reg <= push_data;
            end
            else
                head_reg <= push_data;
        end
        else if (pop)
            head_reg <= tail_reg;
        else if (push)
        begin
            if (head_valid_reg)
                tail_reg <= push_data;
            else
                head_reg <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/prrn_back.sv
// back end: mean by restoring division, root by digit recurrence, result register
// depends on prrn_pkg
`default_nettype none

module prrn_back #(
    parameter int COUNT_BITS = prrn_pkg::COUNT_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  q_valid,
    input  wire logic [63:0]           q_sum,
    input  wire logic [COUNT_BITS-1:0] q_count,
    input  wire logic                  q_flag,
    output logic                       q_pop,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [31:0]                rms_norm,
    output logic [prrn_pkg::OUT_COUNT_BITS-1:0] cells_counted,
    output logic                       saturated
);

    prrn_pkg::back_state_t state_reg, state_next;

    logic [5:0]            step_reg;
    logic [63:0]           quo_reg;
    logic [COUNT_BITS-1:0] rem_reg;
    logic [COUNT_BITS-1:0] div_reg;
    logic [63:0]           rad_reg;
    logic [31:0]           root_reg;
    logic [33:0]           srem_reg;
    logic [31:0]           norm_reg;
    logic                  flag_reg;
    logic [prrn_pkg::OUT_COUNT_BITS-1:0] count_out_reg;

    logic [COUNT_BITS:0] rem_sh;
    logic                div_ge;
    logic [63:0]         quo_step;
    logic [35:0]         srem_sh, trial;
    logic                root_ge;
    logic [31:0]         root_step;

    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[63]};
        div_ge   = rem_sh >= {1'b0, div_reg};
        quo_step = {quo_reg[62:0], div_ge};
        srem_sh  = {srem_reg, rad_reg[63:62]};
        trial    = {2'b00, root_reg, 2'b01};
        root_ge  = srem_sh >= trial;
        root_step = {root_reg[30:0], root_ge};
    end

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        case (state_reg)
            prrn_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    state_next = (q_count == '0) ? prrn_pkg::ST_OUT : prrn_pkg::ST_DIV;
                end
            end
            prrn_pkg::ST_DIV:
            begin
                if (step_reg == 6'(prrn_pkg::DIV_STEPS - 1))
                    state_next = (quo_step[63:48] != 16'h0000) ? prrn_pkg::ST_OUT
                                                               : prrn_pkg::ST_ROOT;
            end
            prrn_pkg::ST_ROOT:
            begin
                if (step_reg == 6'(prrn_pkg::ROOT_STEPS - 1))
                    state_next = prrn_pkg::ST_OUT;
            end
            prrn_pkg::ST_OUT:
            begin
                if (!out_stall)
                    state_next = prrn_pkg::ST_IDLE;
            end
            default:
                state_next = prrn_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= prrn_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            prrn_pkg::ST_IDLE:
            begin
                quo_reg       <= q_sum;
                rem_reg       <= '0;
                div_reg       <= q_count;
                flag_reg      <= q_flag;
                count_out_reg <= prrn_pkg::OUT_COUNT_BITS'(q_count);
                step_reg      <= '0;
                norm_reg      <= '0;
            end
            prrn_pkg::ST_DIV:
            begin
                rem_reg  <= div_ge ? COUNT_BITS'(rem_sh - {1'b0, div_reg})
                                   : COUNT_BITS'(rem_sh);
                quo_reg  <= quo_step;
                if (step_reg == 6'(prrn_pkg::DIV_STEPS - 1))
                begin
                    // mean too large for a 32-bit root
                    if (quo_step[63:48] != 16'h0000)
                    begin
                        norm_reg <= '1;
                        flag_reg <= 1'b1;
                    end
                    rad_reg  <= {quo_step[47:0], 16'h0000};
                    root_reg <= '0;
                    srem_reg <= '0;
                    step_reg <= '0;
                end
                else
                    step_reg <= step_reg + 6'd1;
            end
            prrn_pkg::ST_ROOT:
            begin
                srem_reg <= root_ge ? 34'(srem_sh - trial) : 34'(srem_sh);
                root_reg <= root_step;
                rad_reg  <= {rad_reg[61:0], 2'b00};
                step_reg <= step_reg + 6'd1;
                if (step_reg == 6'(prrn_pkg::ROOT_STEPS - 1))
                    norm_reg <= root_step;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid     = (state_reg == prrn_pkg::ST_OUT);
    assign rms_norm      = norm_reg;
    assign cells_counted = count_out_reg;
    assign saturated     = flag_reg;

endmodule

`default_nettype wire

FILE: rtl/poisson_residual_rms_norm_unit.sv
// Residual RMS norm of a 5-point Poisson stencil over a stream of cells.
// A six-stage front pipeline takes one cell word per cycle, forms the residual,
// squares it and adds it to a saturating 64-bit sum with a cell count. A cell
// marked last hands a snapshot of sum, count and flag to a two-word queue; the
// back end then loads it, runs 64 steps of restoring division for the mean and
// 32 steps of the digit-by-digit root, and holds the result until taken; a zero
// count skips both, and a mean too large for the root skips the root. Input stalls
// only while a last cell meets a full queue, so outside those stalls cells
// stream at one per cycle.
// depends on prrn_pkg, prrn_front, prrn_queue, prrn_back and the macros header
`default_nettype none

`include "poisson_residual_rms_norm_unit_macros.svh"

module poisson_residual_rms_norm_unit #(
    parameter int COUNT_BITS = prrn_pkg::COUNT_BITS_DEF,
    parameter int VALUE_BITS = prrn_pkg::VALUE_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [prrn_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [31:0]           cfg_wdata,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic signed [31:0]    cell_value,
    input  wire logic signed [31:0]    east_face,
    input  wire logic signed [31:0]    west_face,
    input  wire logic signed [31:0]    north_face,
    input  wire logic signed [31:0]    south_face,
    input  wire logic signed [31:0]    source_term,
    input  wire logic                  first_cell,
    input  wire logic                  last_cell,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [31:0]                rms_norm,
    output logic [prrn_pkg::OUT_COUNT_BITS-1:0] cells_counted,
    output logic                       saturated
);

    localparam int SNAP_BITS = 64 + COUNT_BITS + 1;

    logic [31:0] inv_dx_sq_reg, inv_dy_sq_reg;

    logic                  q_push, q_pop, q_full, q_not_empty;
    logic [63:0]           snap_sum;
    logic [COUNT_BITS-1:0] snap_count;
    logic                  snap_flag;
    logic [SNAP_BITS-1:0]  head_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_dx_sq_reg <= prrn_pkg::INV_SQ_RESET;
            inv_dy_sq_reg <= prrn_pkg::INV_SQ_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                prrn_pkg::CFG_INV_DX_SQ: inv_dx_sq_reg <= cfg_wdata;
                prrn_pkg::CFG_INV_DY_SQ: inv_dy_sq_reg <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    prrn_front #(
        .COUNT_BITS (COUNT_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cell_value  (cell_value),
        .east_face   (east_face),
        .west_face   (west_face),
        .north_face  (north_face),
        .south_face  (south_face),
        .source_term (source_term),
        .first_cell  (first_cell),
        .last_cell   (last_cell),
        .inv_dx_sq   (inv_dx_sq_reg),
        .inv_dy_sq   (inv_dy_sq_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .snap_sum    (snap_sum),
        .snap_count  (snap_count),
        .snap_flag   (snap_flag)
    );

    prrn_queue #(
        .WIDTH (SNAP_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({snap_flag, snap_count, snap_sum}),
        .pop       (q_pop),
        .head_data (head_data),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    prrn_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_not_empty),
        .q_sum         (head_data[63:0]),
        .q_count       (head_data[64 +: COUNT_BITS]),
        .q_flag        (head_data[SNAP_BITS-1]),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .rms_norm      (rms_norm),
        .cells_counted (cells_counted),
        .saturated     (saturated)
    );

    `PRRN_ASSERT_IMP(a_no_push_full, clk, rst_n, q_push, !q_full || q_pop, "snapshot pushed into a full queue")
    `PRRN_ASSERT_IMP(a_no_pop_empty, clk, rst_n, q_pop, q_not_empty, "snapshot popped from an empty queue")
    `PRRN_ASSERT_IMP(a_stall_cause, clk, rst_n, in_stall, q_full, "input stalled with room in the queue")
    `PRRN_ASSERT_NXT(a_pop_then_work, clk, rst_n, q_pop, !out_valid, "result shown right after a snapshot was taken")

endmodule

`default_nettype wire
